/* sv/ellr_pkg.sv */
// Shared types and constants for the ellipse row rasterizer.
package ellr_pkg;

  // Fixed field widths
  localparam int COORD_W  = 15;  // origin registers
  localparam int POINT_W  = 16;  // emitted coordinates
  localparam int DIM_W    = 7;   // box width and height
  localparam int ROW_W    = 6;   // row offset
  localparam int GLYPH_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Arithmetic widths: squares of sizes up to 127, and their products
  localparam int SQ_W   = 14;
  localparam int PROD_W = 28;
  localparam int SUM_W  = 29;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_BOX_WIDTH  = 3'd2,
    REG_BOX_HEIGHT = 3'd3,
    REG_FILL_MODE  = 3'd4,
    REG_GLYPH      = 3'd5
  } reg_idx_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_H2,     // h*h
    OP_W2,     // w*w
    OP_B2,     // |b|*|b|
    OP_B2W2,   // b^2 * w^2
    OP_BOUND,  // w^2 * h^2
    OP_A0SQ,   // (w-1)^2
    OP_T0,     // a0^2 * h^2
    OP_D0,     // first increment of a^2 h^2
    OP_COL     // emit one column, step to the next
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    logic   load;
    dp_op_t op;
  } ellr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;  // current request yields no columns
    logic last;   // column being emitted is the final one
  } ellr_stat_t;

  // Configuration register set
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]   box_width;
    logic [DIM_W-1:0]   box_height;
    logic               fill_mode;
    logic [GLYPH_W-1:0] glyph;
  } ellr_cfg_t;

endpackage

/* sv/ellipse_row_rasterizer_top.sv */
// Top level of the ellipse row rasterizer: config registers, sequencer, datapath.
//
// A start transaction with a row offset is taken whenever busy is low. A row that
// lies at or beyond the box height, or a box of zero width or height, produces no
// results and leaves busy low. Otherwise busy is high through the row setup and
// the sweep: setup multiplies on one shared 14x14 multiplier, then w columns (w =
// box width, capped at MAX_SIZE and at 127), one column per cycle. Results appear
// on the out_ ports from a result register, one per cycle, left to right, each
// marked by out_valid for a single cycle. The receiver cannot stall them, so it
// must take every strobe. A new row can be taken at the edge that takes the final
// column. The final column of a row carries out_last_in_row. Configuration is
// written through cfg_valid / cfg_ready (always ready) and must only change while
// busy is low and no result is still due.
module ellipse_row_rasterizer_top
  import ellr_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request
  input  logic                      start,
  output logic                      busy,
  input  logic [ROW_W-1:0]          in_row_index,
  // results
  output logic                      out_valid,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  output logic                      out_plotted,
  output logic [GLYPH_W-1:0]        out_glyph_out,
  output logic                      out_last_in_row,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  ellr_cfg_t  cfg;
  ellr_cmd_t  cmd;
  ellr_stat_t stat;

  ellr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ellr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ellr_dp #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .row_index       (in_row_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_plotted     (out_plotted),
    .out_glyph_out   (out_glyph_out),
    .out_last_in_row (out_last_in_row)
  );

  // The last column of a row ends the sweep in the same cycle it is shown
  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_in_row |-> !busy)
    else $error("busy still high with the last column of a row");

  // Any earlier column leaves the sweep running
  a_mid_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_in_row |-> busy)
    else $error("sweep stopped before the last column");

  // A non-empty request starts a row
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !stat.empty |=> busy)
    else $error("accepted row did not raise busy");

  // An unplotted cell carries no glyph
  a_glyph_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_plotted |-> out_glyph_out == '0)
    else $error("glyph on an unplotted cell");

endmodule

/* sv/ellr_cfg.sv */
// Configuration register file for the ellipse row rasterizer.
module ellr_cfg
  import ellr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ellr_cfg_t             cfg
);

  ellr_cfg_t cfg_r;
  ellr_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode one write transaction; unknown indexes leave everything alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   cfg_nxt.origin_x   = cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:   cfg_nxt.origin_y   = cfg_data[COORD_W-1:0];
        REG_BOX_WIDTH:  cfg_nxt.box_width  = cfg_data[DIM_W-1:0];
        REG_BOX_HEIGHT: cfg_nxt.box_height = cfg_data[DIM_W-1:0];
        REG_FILL_MODE:  cfg_nxt.fill_mode  = cfg_data[0];
        REG_GLYPH:      cfg_nxt.glyph      = cfg_data[GLYPH_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/ellr_ctrl.sv */
// Sequencer: setup multiplies for a row, then one column per cycle.
module ellr_ctrl
  import ellr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ellr_stat_t stat,
  output ellr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_H2, S_W2, S_B2, S_B2W2, S_BOUND, S_A0SQ, S_T0, S_D0, S_COL
  } state_t;

  state_t state_r;
  dp_op_t op_r;
  logic   busy_r;

  assign busy     = busy_r;
  assign cmd.load = start && !busy_r && !stat.empty;
  assign cmd.op   = op_r;

  // State and registered command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start && !stat.empty) begin
            state_r <= S_H2;
            op_r    <= OP_H2;
            busy_r  <= 1'b1;
          end
        end
        S_H2: begin
          state_r <= S_W2;
          op_r    <= OP_W2;
        end
        S_W2: begin
          state_r <= S_B2;
          op_r    <= OP_B2;
        end
        S_B2: begin
          state_r <= S_B2W2;
          op_r    <= OP_B2W2;
        end
        S_B2W2: begin
          state_r <= S_BOUND;
          op_r    <= OP_BOUND;
        end
        S_BOUND: begin
          state_r <= S_A0SQ;
          op_r    <= OP_A0SQ;
        end
        S_A0SQ: begin
          state_r <= S_T0;
          op_r    <= OP_T0;
        end
        S_T0: begin
          state_r <= S_D0;
          op_r    <= OP_D0;
        end
        S_D0: begin
          state_r <= S_COL;
          op_r    <= OP_COL;
        end
        S_COL: begin
          if (stat.last) begin
            state_r <= S_IDLE;
            op_r    <= OP_NONE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          op_r    <= OP_NONE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* sv/ellr_dp.sv */
// Datapath: shared setup multiplier, incremental a^2 h^2, column output register.
module ellr_dp
  import ellr_pkg::*;
#(
  parameter int MAX_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ellr_cfg_t                 cfg,
  input  logic [ROW_W-1:0]          row_index,
  input  ellr_cmd_t                 cmd,
  output ellr_stat_t                stat,
  output logic                      out_valid,
  output logic signed [POINT_W-1:0] out_point_x,
  output logic signed [POINT_W-1:0] out_point_y,
  output logic                      out_plotted,
  output logic [GLYPH_W-1:0]        out_glyph_out,
  output logic                      out_last_in_row
);

  // Sizes above MAX_SIZE act as MAX_SIZE; the 7-bit register caps at 127
  localparam int DimCapInt = (MAX_SIZE > 127) ? 127 : MAX_SIZE;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DimCapInt);

  logic [DIM_W-1:0] w_cl, h_cl, babs_in;
  logic [DIM_W:0]   two_row, hm1;

  // Per-row registers
  logic [DIM_W-1:0]         w_r, wm1_r, babs_r, dx_r;
  logic [POINT_W-1:0]       py_r;
  logic [SQ_W-1:0]          h2_r, w2_r, b2_r, a0sq_r;
  logic [PROD_W-1:0]        b2w2_r, bound_r, t_r;
  logic signed [PROD_W-1:0] d_r;

  // Shared multiplier
  logic [SQ_W-1:0]   mul_x, mul_y;
  logic [PROD_W-1:0] prod;

  // Column evaluation
  logic [SUM_W-1:0]   s_sum;
  logic               in_ellipse, band, plot;
  logic [POINT_W-1:0] px;

  // Clamped sizes and emptiness of the incoming request
  assign w_cl    = (cfg.box_width  > DIM_CAP) ? DIM_CAP : cfg.box_width;
  assign h_cl    = (cfg.box_height > DIM_CAP) ? DIM_CAP : cfg.box_height;
  assign two_row = {1'b0, row_index, 1'b0};
  assign hm1     = {1'b0, h_cl} - 8'd1;
  assign babs_in = (two_row >= hm1) ? DIM_W'(two_row - hm1) : DIM_W'(hm1 - two_row);

  assign stat.empty = (w_cl == '0) || (h_cl == '0) || ({1'b0, row_index} >= h_cl);
  assign stat.last  = (dx_r == wm1_r);

  // Operand select for the setup multiplies
  always_comb begin
    case (cmd.op)
      OP_H2:    begin mul_x = SQ_W'(h2_r);   mul_y = SQ_W'(h2_r);   end
      OP_W2:    begin mul_x = SQ_W'(w_r);    mul_y = SQ_W'(w_r);    end
      OP_B2:    begin mul_x = SQ_W'(babs_r); mul_y = SQ_W'(babs_r); end
      OP_B2W2:  begin mul_x = b2_r;          mul_y = w2_r;          end
      OP_BOUND: begin mul_x = w2_r;          mul_y = h2_r;          end
      OP_A0SQ:  begin mul_x = SQ_W'(wm1_r);  mul_y = SQ_W'(wm1_r);  end
      OP_T0:    begin mul_x = a0sq_r;        mul_y = h2_r;          end
      OP_D0:    begin mul_x = SQ_W'(wm1_r);  mul_y = h2_r;          end
      default:  begin mul_x = '0;            mul_y = '0;            end
    endcase
  end

  assign prod = mul_x * mul_y;

  // Inside and outline band tests for the current column
  assign s_sum      = {1'b0, t_r} + {1'b0, b2w2_r};
  assign in_ellipse = s_sum <= {1'b0, bound_r};
  assign band       = {s_sum, 1'b0} >= {2'b00, bound_r};
  assign plot       = in_ellipse && (cfg.fill_mode || band);
  assign px         = {cfg.origin_x[COORD_W-1], cfg.origin_x}
                      + {{(POINT_W-DIM_W){1'b0}}, dx_r};

  // Row setup and column stepping. h2_r holds h itself until OP_H2 squares it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r    <= w_cl;
      wm1_r  <= w_cl - 7'd1;
      h2_r   <= SQ_W'(h_cl);
      babs_r <= babs_in;
      dx_r   <= '0;
      py_r   <= {cfg.origin_y[COORD_W-1], cfg.origin_y}
                + {{(POINT_W-ROW_W){1'b0}}, row_index};
    end else begin
      case (cmd.op)
        OP_H2:    h2_r    <= prod[SQ_W-1:0];
        OP_W2:    w2_r    <= prod[SQ_W-1:0];
        OP_B2:    b2_r    <= prod[SQ_W-1:0];
        OP_B2W2:  b2w2_r  <= prod;
        OP_BOUND: bound_r <= prod;
        OP_A0SQ:  a0sq_r  <= prod[SQ_W-1:0];
        OP_T0:    t_r     <= prod;
        // (4a0 + 4) h^2 with a0 = -(w-1)
        OP_D0:    d_r     <= $signed(PROD_W'({h2_r, 2'b00}) - PROD_W'({prod, 2'b00}));
        OP_COL: begin
          // (a+2)^2 - a^2 = 4a + 4, so the increment grows by 8 h^2 per column
          t_r  <= t_r + $unsigned(d_r);
          d_r  <= d_r + $signed(PROD_W'({h2_r, 3'b000}));
          dx_r <= dx_r + 7'd1;
        end
        default: ;
      endcase
    end
  end

  // Result register, one strobe per column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.op == OP_COL);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COL) begin
      out_point_x     <= $signed(px);
      out_point_y     <= $signed(py_r);
      out_plotted     <= plot;
      out_glyph_out   <= plot ? cfg.glyph : '0;
      out_last_in_row <= stat.last;
    end
  end

endmodule
